// ===== hw/rtl/i2cblm_pkg.sv =====
package i2cblm_pkg;

    // command field
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_START     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STOP      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEND_BYTE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RECV_BYTE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEND_ACK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RECV_ACK  = 3'd5;

    // byte and timing widths
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = 3;
    localparam int HOLD_W        = 16;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd1000;

    // source of the next sda level
    typedef enum logic [1:0] {
        SDA_ONE,
        SDA_ZERO,
        SDA_MSB,
        SDA_ACK
    } sda_sel_t;

    // controller to datapath
    typedef struct packed {
        logic     load;       // latch the request payload
        logic     load_tx;    // shifter takes tx_byte, else clears
        logic     fire;       // perform one line event
        logic     sda_we;
        sda_sel_t sda_sel;
        logic     scl_we;
        logic     scl_val;
        logic     shift;      // shift transmit byte left
        logic     sample;     // shift in one bus level
        logic     rx_out;     // present assembled byte
        logic     ack_out;    // present sampled ack
        logic     last;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic timer_zero;
        logic slot_free;
    } ctrl_stat_t;

endpackage

// ===== hw/rtl/i2cblm_cmd_if.sv =====
interface i2cblm_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [i2cblm_pkg::CMD_W-1:0]      cmd;
    logic [i2cblm_pkg::BITS_PER_BYTE-1:0] tx_byte;
    logic                              ack_level;
    logic [i2cblm_pkg::BITS_PER_BYTE-1:0] bus_sda_levels;

    modport source (output valid, output cmd, output tx_byte, output ack_level,
                    output bus_sda_levels, input ready);
    modport sink (input valid, input cmd, input tx_byte, input ack_level,
                  input bus_sda_levels, output ready);
endinterface

// ===== hw/rtl/i2cblm_evt_if.sv =====
interface i2cblm_evt_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 scl_level;
    logic                                 sda_level;
    logic [i2cblm_pkg::BITS_PER_BYTE-1:0] rx_byte;
    logic                                 ack_in;
    logic                                 last_event;

    modport source (output valid, output scl_level, output sda_level, output rx_byte,
                    output ack_in, output last_event, input ready);
    modport sink (input valid, input scl_level, input sda_level, input rx_byte,
                  input ack_in, input last_event, output ready);
endinterface

// ===== hw/rtl/i2cblm_ctrl.sv =====
module i2cblm_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [i2cblm_pkg::CMD_W-1:0]  in_cmd,
    output logic                          in_ready,
    input  i2cblm_pkg::ctrl_stat_t        stat,
    output i2cblm_pkg::ctrl_cmd_t         ctl
);
    import i2cblm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_BYTE - 1);

    state_t               state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [1:0]           step_reg, step_next;
    logic [BIT_IDX_W-1:0] bit_reg, bit_next;
    logic                 last_reg, last_next;
    logic                 accept;
    logic                 known;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // only defined commands start a sequence
    always_comb
    begin
        case (in_cmd)
            CMD_START, CMD_STOP, CMD_SEND_BYTE, CMD_RECV_BYTE, CMD_SEND_ACK,
            CMD_RECV_ACK: known = 1'b1;
            default:      known = 1'b0;
        endcase
    end

    // event decode for the current step
    always_comb
    begin
        ctl         = '0;
        ctl.sda_sel = SDA_ONE;
        ctl.load    = accept && known;
        ctl.load_tx = (in_cmd == CMD_SEND_BYTE);
        ctl.fire    = (state_reg == ST_RUN) && stat.slot_free;
        step_next   = step_reg + 2'd1;
        bit_next    = bit_reg;
        unique case (cmd_reg)
            CMD_START:
            begin
                ctl.sda_we  = !step_reg[0];
                ctl.sda_sel = (step_reg == 2'd0) ? SDA_ONE : SDA_ZERO;
                ctl.scl_we  = step_reg[0];
                ctl.scl_val = (step_reg == 2'd1);
                ctl.last    = (step_reg == 2'd3);
            end
            CMD_STOP:
            begin
                ctl.sda_we  = !step_reg[0];
                ctl.sda_sel = (step_reg == 2'd0) ? SDA_ZERO : SDA_ONE;
                ctl.scl_we  = step_reg[0];
                ctl.scl_val = 1'b1;
                ctl.last    = (step_reg == 2'd2);
            end
            CMD_SEND_BYTE:
            begin
                ctl.sda_we  = (step_reg == 2'd0);
                ctl.sda_sel = SDA_MSB;
                ctl.scl_we  = (step_reg != 2'd0);
                ctl.scl_val = (step_reg == 2'd1);
                ctl.shift   = (step_reg == 2'd2);
                ctl.last    = (step_reg == 2'd2) && (bit_reg == LAST_BIT);
                if (step_reg == 2'd2)
                begin
                    step_next = 2'd0;
                    bit_next  = bit_reg + 1'b1;
                end
            end
            CMD_RECV_BYTE:
            begin
                ctl.sda_we  = (step_reg == 2'd0);
                ctl.sda_sel = SDA_ONE;
                ctl.scl_we  = (step_reg != 2'd0);
                ctl.scl_val = (step_reg == 2'd1);
                ctl.sample  = (step_reg == 2'd1);
                ctl.rx_out  = (step_reg == 2'd2) && (bit_reg == LAST_BIT);
                ctl.last    = ctl.rx_out;
                if (step_reg == 2'd2)
                begin
                    step_next = 2'd1;
                    bit_next  = bit_reg + 1'b1;
                end
            end
            CMD_SEND_ACK, CMD_RECV_ACK:
            begin
                ctl.sda_we  = (step_reg == 2'd0);
                ctl.sda_sel = (cmd_reg == CMD_SEND_ACK) ? SDA_ACK : SDA_ONE;
                ctl.scl_we  = (step_reg != 2'd0);
                ctl.scl_val = (step_reg == 2'd1);
                ctl.ack_out = (cmd_reg == CMD_RECV_ACK) && (step_reg == 2'd2);
                ctl.last    = (step_reg == 2'd2);
            end
            default:
            begin
                ctl.fire = 1'b0;
            end
        endcase
        if (ctl.last)
        begin
            step_next = 2'd0;
            bit_next  = '0;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && known)
                begin
                    cmd_next   = in_cmd;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (ctl.fire)
                begin
                    last_next  = ctl.last;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (stat.timer_zero)
                    state_next = last_reg ? ST_IDLE : ST_RUN;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= CMD_START;
            step_reg  <= 2'd0;
            bit_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            last_reg  <= last_next;
            if (ctl.fire)
            begin
                step_reg <= step_next;
                bit_reg  <= bit_next;
            end
        end
    end

    a_fire_then_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire |=> state_reg == ST_HOLD)
        else $error("event not followed by hold");

    a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> (step_reg == 2'd0) && (bit_reg == '0))
        else $error("counters not cleared at end of sequence");

    a_known_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && known |=> state_reg == ST_RUN)
        else $error("accepted request did not start");

endmodule

// ===== hw/rtl/i2cblm_datapath.sv =====
module i2cblm_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [i2cblm_pkg::HOLD_W-1:0]        cfg_wr_data,
    input  logic [i2cblm_pkg::BITS_PER_BYTE-1:0] tx_byte,
    input  logic                                 ack_level,
    input  logic [i2cblm_pkg::BITS_PER_BYTE-1:0] bus_sda_levels,
    input  i2cblm_pkg::ctrl_cmd_t                ctl,
    output i2cblm_pkg::ctrl_stat_t               stat,
    i2cblm_evt_if.source                         evt
);
    import i2cblm_pkg::*;

    localparam int MSB = BITS_PER_BYTE - 1;

    logic [HOLD_W-1:0]        hold_reg;
    logic [HOLD_W-1:0]        timer_reg;
    logic                     scl_reg, sda_reg;
    logic                     scl_next, sda_next;
    logic [BITS_PER_BYTE-1:0] shift_reg;
    logic [BITS_PER_BYTE-1:0] bus_reg;
    logic                     ack_reg;
    logic                     out_valid_reg;
    logic                     out_scl_reg, out_sda_reg, out_ack_reg, out_last_reg;
    logic [BITS_PER_BYTE-1:0] out_rx_reg;

    assign stat.timer_zero = (timer_reg == '0);
    assign stat.slot_free  = !out_valid_reg || evt.ready;

    // line levels after this event
    always_comb
    begin
        scl_next = ctl.scl_we ? ctl.scl_val : scl_reg;
        sda_next = sda_reg;
        if (ctl.sda_we)
        begin
            unique case (ctl.sda_sel)
                SDA_ONE:  sda_next = 1'b1;
                SDA_ZERO: sda_next = 1'b0;
                SDA_MSB:  sda_next = shift_reg[MSB];
                SDA_ACK:  sda_next = ack_reg;
                default:  sda_next = 1'b1;
            endcase
        end
    end

    // hold register, line drivers, shifter and hold timer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg  <= HOLD_RESET;
            timer_reg <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            shift_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                hold_reg <= cfg_wr_data;
            if (ctl.load)
            begin
                shift_reg <= ctl.load_tx ? tx_byte : '0;
            end
            else if (ctl.fire && ctl.shift)
            begin
                shift_reg <= {shift_reg[MSB-1:0], 1'b0};
            end
            else if (ctl.fire && ctl.sample)
            begin
                shift_reg <= {shift_reg[MSB-1:0], bus_reg[MSB]};
            end
            if (ctl.fire)
            begin
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                timer_reg <= hold_reg;
            end
            else if (timer_reg != '0)
            begin
                timer_reg <= timer_reg - 1'b1;
            end
        end
    end

    // request payload kept for the sequence
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            bus_reg <= bus_sda_levels;
            ack_reg <= ack_level;
        end
        else if (ctl.fire && ctl.sample)
        begin
            bus_reg <= {bus_reg[MSB-1:0], 1'b0};
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.fire)
            out_valid_reg <= 1'b1;
        else if (evt.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            out_scl_reg  <= scl_next;
            out_sda_reg  <= sda_next;
            out_rx_reg   <= ctl.rx_out ? shift_reg : '0;
            out_ack_reg  <= ctl.ack_out ? bus_reg[MSB] : 1'b0;
            out_last_reg <= ctl.last;
        end
    end

    assign evt.valid      = out_valid_reg;
    assign evt.scl_level  = out_scl_reg;
    assign evt.sda_level  = out_sda_reg;
    assign evt.rx_byte    = out_rx_reg;
    assign evt.ack_in     = out_ack_reg;
    assign evt.last_event = out_last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire |-> !out_valid_reg || evt.ready)
        else $error("result overwritten before it was taken");

    a_rx_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_last_reg |-> out_rx_reg == '0)
        else $error("received byte shown before last event");

    a_ack_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_last_reg |-> !out_ack_reg)
        else $error("ack shown before last event");

endmodule

// ===== hw/rtl/i2c_bit_level_master_core.sv =====
// I2C bit-level master.
// cmd_ch carries one request: cmd (start, stop, send byte, receive byte,
// send ack, receive ack), the byte to send, the ack level to drive and the
// SDA levels the bus presents at the SCL-high sample points, MSB first.
// evt_ch gives one result per line event: SCL and SDA levels after the
// event, the received byte or sampled ack on the final event, and a flag
// that marks the final event of the request.
// cfg_wr_en / cfg_wr_data set the hold timer's reload value, which sets how long each event is held;
// write it only while the block is idle.
// Requests are taken one at a time: a request takes 3 to 24 events, each
// held by the hold timer in the datapath. A taken request moves the
// sequencer to its run state, where the first event fires into the result
// register; undefined command codes are accepted and dropped.
// When evt_ch stalls, an event waits in the result register and the next
// event is held back until it is taken; the hold timer keeps running.
// A new request is taken once the hold of the last event has run out.
// Reset releases both lines, clears the sequencer and loads HOLD_RESET into the hold register.
module i2c_bit_level_master_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [i2cblm_pkg::HOLD_W-1:0]  cfg_wr_data,
    i2cblm_cmd_if.sink                     cmd_ch,
    i2cblm_evt_if.source                   evt_ch
);
    import i2cblm_pkg::*;

    ctrl_cmd_t  ctl;
    ctrl_stat_t stat;

    // sequencer
    i2cblm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_ch.valid),
        .in_cmd   (cmd_ch.cmd),
        .in_ready (cmd_ch.ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // line state, shifters, timer and result register
    i2cblm_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .tx_byte        (cmd_ch.tx_byte),
        .ack_level      (cmd_ch.ack_level),
        .bus_sda_levels (cmd_ch.bus_sda_levels),
        .ctl            (ctl),
        .stat           (stat),
        .evt            (evt_ch)
    );

endmodule
